// ===== src/pfr_pkg.sv =====
package pfr_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_BUFFER_CAPACITY  = 3'd0,
      CSR_TIMEOUT_LIMIT    = 3'd1,
      CSR_CANCEL_CODE      = 3'd2,
      CSR_FINISH_CODE      = 3'd3,
      CSR_FILE_SIZE_CODE   = 3'd4,
      CSR_PACKET_SIZE_CODE = 3'd5,
      CSR_PAYLOAD_CODE     = 3'd6,
      CSR_ACK_CODE         = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_STORE = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_NO_RESPONSE = 3'd1,
      STATUS_CANCEL      = 3'd2,
      STATUS_SYNC        = 3'd3,
      STATUS_OVERFLOW    = 3'd4,
      STATUS_EMPTY       = 3'd5,
      STATUS_CHECKSUM    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      STG_FILE   = 2'd0,
      STG_PACKET = 2'd1,
      STG_DATA   = 2'd2,
      STG_BAD    = 2'd3
   } stage_type;

   typedef enum logic [1:0] {
      PH_CMD  = 2'd0,
      PH_SIZE = 2'd1,
      PH_DATA = 2'd2,
      PH_SUM  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [31:0] buffer_capacity;
      logic [31:0] timeout_limit;
      logic [7:0]  cancel_code;
      logic [7:0]  finish_code;
      logic [7:0]  file_size_code;
      logic [7:0]  packet_size_code;
      logic [7:0]  payload_code;
      logic [7:0]  ack_code;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [31:0] store_index;
      status_type  status;
      logic [31:0] received_total;
   } rsp_type;

   localparam logic [31:0] BufferCapacityReset = 32'd65536;
   localparam logic [31:0] TimeoutLimitReset   = 32'd1000;
   localparam logic [7:0]  CancelCodeReset     = 8'd24;
   localparam logic [7:0]  FinishCodeReset     = 8'd4;
   localparam logic [7:0]  FileSizeCodeReset   = 8'd1;
   localparam logic [7:0]  PacketSizeCodeReset = 8'd2;
   localparam logic [7:0]  PayloadCodeReset    = 8'd3;
   localparam logic [7:0]  AckCodeReset        = 8'd6;

   localparam logic [15:0] FileSizeBytes   = 16'd4;
   localparam logic [15:0] PacketSizeBytes = 16'd2;

endpackage

// ===== src/pfr_csr.sv =====
module pfr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [pfr_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [pfr_pkg::CsrDataWidth-1:0]     csr_wr_data,
   output pfr_pkg::cfg_type                     cfg
);

   pfr_pkg::cfg_type cfg_ff;
   pfr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (pfr_pkg::csr_index_type'(csr_index))
            pfr_pkg::CSR_BUFFER_CAPACITY:  cfg_in.buffer_capacity  = csr_wr_data;
            pfr_pkg::CSR_TIMEOUT_LIMIT:    cfg_in.timeout_limit    = csr_wr_data;
            pfr_pkg::CSR_CANCEL_CODE:      cfg_in.cancel_code      = csr_wr_data[7:0];
            pfr_pkg::CSR_FINISH_CODE:      cfg_in.finish_code      = csr_wr_data[7:0];
            pfr_pkg::CSR_FILE_SIZE_CODE:   cfg_in.file_size_code   = csr_wr_data[7:0];
            pfr_pkg::CSR_PACKET_SIZE_CODE: cfg_in.packet_size_code = csr_wr_data[7:0];
            pfr_pkg::CSR_PAYLOAD_CODE:     cfg_in.payload_code     = csr_wr_data[7:0];
            pfr_pkg::CSR_ACK_CODE:         cfg_in.ack_code         = csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_capacity  <= pfr_pkg::BufferCapacityReset;
         cfg_ff.timeout_limit    <= pfr_pkg::TimeoutLimitReset;
         cfg_ff.cancel_code      <= pfr_pkg::CancelCodeReset;
         cfg_ff.finish_code      <= pfr_pkg::FinishCodeReset;
         cfg_ff.file_size_code   <= pfr_pkg::FileSizeCodeReset;
         cfg_ff.packet_size_code <= pfr_pkg::PacketSizeCodeReset;
         cfg_ff.payload_code     <= pfr_pkg::PayloadCodeReset;
         cfg_ff.ack_code         <= pfr_pkg::AckCodeReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/pfr_core.sv =====
module pfr_core (
   input  logic              clock,
   input  logic              reset,
   input  pfr_pkg::cfg_type  cfg,
   input  logic              fire,
   input  logic [1:0]        op,
   input  logic [7:0]        rx_byte,
   output logic              emit,
   output pfr_pkg::rsp_type  rsp
);

   logic                 active_ff, active_in;
   pfr_pkg::stage_type   stage_ff, stage_in;
   pfr_pkg::phase_type   phase_ff, phase_in;
   logic [15:0]          byte_count_ff, byte_count_in;
   logic [31:0]          file_size_ff, file_size_in;
   logic [15:0]          packet_length_ff, packet_length_in;
   logic [7:0]           running_sum_ff, running_sum_in;
   logic [31:0]          total_ff, total_in;
   logic [31:0]          write_offset_ff, write_offset_in;
   logic [32:0]          idle_ticks_ff, idle_ticks_in;

   pfr_pkg::op_type      op_code;
   logic [32:0]          tick_count;
   logic                 timed_out;
   logic [15:0]          count_inc;
   logic [31:0]          size_merged;
   logic [15:0]          length_merged;
   logic [7:0]           sum_next;
   logic                 is_cancel;
   logic                 is_finish;
   logic                 cmd_match;

   always_comb begin
      op_code       = pfr_pkg::op_type'(op);
      tick_count    = idle_ticks_ff + 33'd1;
      timed_out     = tick_count > {1'b0, cfg.timeout_limit};
      count_inc     = byte_count_ff + 16'd1;
      size_merged   = file_size_ff | ({24'b0, rx_byte} << {byte_count_ff[1:0], 3'b000});
      length_merged = packet_length_ff | ({8'b0, rx_byte} << {byte_count_ff[0], 3'b000});
      sum_next      = running_sum_ff + rx_byte;
      is_cancel     = rx_byte == cfg.cancel_code;
      is_finish     = rx_byte == cfg.finish_code;
      unique case (stage_ff)
         pfr_pkg::STG_FILE:   cmd_match = rx_byte == cfg.file_size_code;
         pfr_pkg::STG_PACKET: cmd_match = rx_byte == cfg.packet_size_code;
         pfr_pkg::STG_DATA:   cmd_match = rx_byte == cfg.payload_code;
         default:             cmd_match = 1'b0;
      endcase
   end

   // Result for the word held at the input register
   always_comb begin
      emit               = 1'b0;
      rsp.kind           = pfr_pkg::KIND_END;
      rsp.data_byte      = 8'd0;
      rsp.store_index    = 32'd0;
      rsp.status         = pfr_pkg::STATUS_OK;
      rsp.received_total = total_ff;
      if (active_ff) begin
         unique case (op_code)
            pfr_pkg::OP_BYTE: begin
               unique case (phase_ff)
                  pfr_pkg::PH_CMD: begin
                     priority if (is_cancel) begin
                        emit       = 1'b1;
                        rsp.status = pfr_pkg::STATUS_CANCEL;
                     end else if (is_finish) begin
                        emit       = 1'b1;
                     end else if (!cmd_match) begin
                        emit       = 1'b1;
                        rsp.status = pfr_pkg::STATUS_SYNC;
                     end
                  end
                  pfr_pkg::PH_SIZE: begin
                     if (stage_ff == pfr_pkg::STG_FILE) begin
                        if (count_inc >= pfr_pkg::FileSizeBytes) begin
                           priority if (cfg.buffer_capacity < size_merged) begin
                              emit       = 1'b1;
                              rsp.status = pfr_pkg::STATUS_OVERFLOW;
                           end else if (size_merged == 32'd0) begin
                              emit       = 1'b1;
                              rsp.status = pfr_pkg::STATUS_EMPTY;
                           end
                        end
                     end else if (stage_ff != pfr_pkg::STG_PACKET) begin
                        emit       = 1'b1;
                        rsp.status = pfr_pkg::STATUS_SYNC;
                     end
                  end
                  pfr_pkg::PH_DATA: begin
                     emit            = 1'b1;
                     rsp.kind        = pfr_pkg::KIND_STORE;
                     rsp.data_byte   = rx_byte;
                     rsp.store_index = write_offset_ff;
                  end
                  pfr_pkg::PH_SUM: begin
                     emit = 1'b1;
                     if (rx_byte != running_sum_ff) begin
                        rsp.status = pfr_pkg::STATUS_CHECKSUM;
                     end else begin
                        rsp.kind      = pfr_pkg::KIND_ACK;
                        rsp.data_byte = cfg.ack_code;
                     end
                  end
                  default: ;
               endcase
            end
            pfr_pkg::OP_TICK: begin
               if (timed_out) begin
                  emit       = 1'b1;
                  rsp.status = pfr_pkg::STATUS_NO_RESPONSE;
               end
            end
            default: ;
         endcase
      end
   end

   // Transfer state for the word held at the input register
   always_comb begin
      active_in        = active_ff;
      stage_in         = stage_ff;
      phase_in         = phase_ff;
      byte_count_in    = byte_count_ff;
      file_size_in     = file_size_ff;
      packet_length_in = packet_length_ff;
      running_sum_in   = running_sum_ff;
      total_in         = total_ff;
      write_offset_in  = write_offset_ff;
      idle_ticks_in    = idle_ticks_ff;
      if (fire) begin
         unique case (op_code)
            pfr_pkg::OP_START: begin
               active_in        = 1'b1;
               stage_in         = pfr_pkg::STG_FILE;
               phase_in         = pfr_pkg::PH_CMD;
               byte_count_in    = 16'd0;
               file_size_in     = 32'd0;
               packet_length_in = 16'd0;
               running_sum_in   = 8'd0;
               total_in         = 32'd0;
               write_offset_in  = 32'd0;
               idle_ticks_in    = 33'd0;
            end
            pfr_pkg::OP_BYTE: begin
               if (active_ff) begin
                  idle_ticks_in = 33'd0;
                  unique case (phase_ff)
                     pfr_pkg::PH_CMD: begin
                        priority if (is_cancel || is_finish || !cmd_match) begin
                           active_in = 1'b0;
                        end else if (stage_ff == pfr_pkg::STG_FILE) begin
                           file_size_in  = 32'd0;
                           byte_count_in = 16'd0;
                           phase_in      = pfr_pkg::PH_SIZE;
                        end else if (stage_ff == pfr_pkg::STG_PACKET) begin
                           packet_length_in = 16'd0;
                           byte_count_in    = 16'd0;
                           phase_in         = pfr_pkg::PH_SIZE;
                        end else begin
                           running_sum_in = 8'd0;
                           byte_count_in  = 16'd0;
                           phase_in       = (packet_length_ff == 16'd0) ?
                                            pfr_pkg::PH_SUM : pfr_pkg::PH_DATA;
                        end
                     end
                     pfr_pkg::PH_SIZE: begin
                        priority if (stage_ff == pfr_pkg::STG_FILE) begin
                           file_size_in  = size_merged;
                           byte_count_in = count_inc;
                           if (count_inc >= pfr_pkg::FileSizeBytes) begin
                              stage_in = pfr_pkg::STG_PACKET;
                              phase_in = pfr_pkg::PH_CMD;
                              if (cfg.buffer_capacity < size_merged || size_merged == 32'd0) begin
                                 active_in = 1'b0;
                              end
                           end
                        end else if (stage_ff == pfr_pkg::STG_PACKET) begin
                           packet_length_in = length_merged;
                           byte_count_in    = count_inc;
                           if (count_inc >= pfr_pkg::PacketSizeBytes) begin
                              total_in = total_ff + {16'd0, length_merged};
                              stage_in = pfr_pkg::STG_DATA;
                              phase_in = pfr_pkg::PH_CMD;
                           end
                        end else begin
                           active_in = 1'b0;
                        end
                     end
                     pfr_pkg::PH_DATA: begin
                        write_offset_in = write_offset_ff + 32'd1;
                        running_sum_in  = sum_next;
                        byte_count_in   = count_inc;
                        if (count_inc >= packet_length_ff) begin
                           phase_in = pfr_pkg::PH_SUM;
                        end
                     end
                     pfr_pkg::PH_SUM: begin
                        if (rx_byte != running_sum_ff) begin
                           active_in = 1'b0;
                        end else begin
                           stage_in = pfr_pkg::STG_PACKET;
                           phase_in = pfr_pkg::PH_CMD;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            pfr_pkg::OP_TICK: begin
               if (active_ff) begin
                  idle_ticks_in = tick_count;
                  if (timed_out) begin
                     active_in = 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff        <= 1'b0;
         stage_ff         <= pfr_pkg::STG_FILE;
         phase_ff         <= pfr_pkg::PH_CMD;
         byte_count_ff    <= 16'd0;
         file_size_ff     <= 32'd0;
         packet_length_ff <= 16'd0;
         running_sum_ff   <= 8'd0;
         total_ff         <= 32'd0;
         write_offset_ff  <= 32'd0;
         idle_ticks_ff    <= 33'd0;
      end else begin
         active_ff        <= active_in;
         stage_ff         <= stage_in;
         phase_ff         <= phase_in;
         byte_count_ff    <= byte_count_in;
         file_size_ff     <= file_size_in;
         packet_length_ff <= packet_length_in;
         running_sum_ff   <= running_sum_in;
         total_ff         <= total_in;
         write_offset_ff  <= write_offset_in;
         idle_ticks_ff    <= idle_ticks_in;
      end
   end

   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      fire && op_code == pfr_pkg::OP_START |=>
         active_ff && stage_ff == pfr_pkg::STG_FILE && phase_ff == pfr_pkg::PH_CMD
         && write_offset_ff == 32'd0 && total_ff == 32'd0)
      else $error("start did not arm a clean transfer");

   a_end_disarms: assert property (@(posedge clock) disable iff (reset)
      fire && emit && rsp.kind == pfr_pkg::KIND_END |=> !active_ff)
      else $error("transfer still active after end word");

   a_store_advances: assert property (@(posedge clock) disable iff (reset)
      fire && emit && rsp.kind == pfr_pkg::KIND_STORE |=>
         write_offset_ff == $past(write_offset_ff) + 32'd1)
      else $error("store offset did not advance");

   a_idle_no_emit: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> !emit)
      else $error("result raised while no transfer active");

endmodule

// ===== src/packet_file_receiver.sv =====
// Path: an accepted word is held in the input register; its result (if any) is registered in the
// result register, which drives rsp_*, once the result register is free.
// Throughput: one word per cycle; a stalled result register holds a word that raises a result in
// the input register, which keeps accepting only once the held word is processed.
// Reset: synchronous, active high; clears the transfer (idle, waiting for start), both
// registers' valid flags and loads the configuration registers with their defaults.
module packet_file_receiver (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_op,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_kind,
   output logic [7:0]                         rsp_data_byte,
   output logic [31:0]                        rsp_store_index,
   output logic [2:0]                         rsp_status,
   output logic [31:0]                        rsp_received_total,
   input  logic                               csr_wr_en,
   input  logic [pfr_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [pfr_pkg::CsrDataWidth-1:0]   csr_wr_data
);

   pfr_pkg::cfg_type  cfg;
   pfr_pkg::rsp_type  core_rsp;
   logic              core_emit;

   logic              in_valid_ff, in_valid_in;
   logic [1:0]        in_op_ff;
   logic [7:0]        in_byte_ff;
   logic              out_valid_ff, out_valid_in;
   pfr_pkg::rsp_type  out_ff;

   logic              out_free;
   logic              consume;
   logic              req_accept;

   pfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   pfr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .fire    (consume),
      .op      (in_op_ff),
      .rx_byte (in_byte_ff),
      .emit    (core_emit),
      .rsp     (core_rsp)
   );

   // A held word that raises no result never waits for the output side
   assign out_free   = !out_valid_ff || rsp_ready;
   assign consume    = in_valid_ff && (!core_emit || out_free);
   assign req_ready  = !in_valid_ff || consume;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (consume && core_emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_rx_byte;
      end
      if (consume && core_emit) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_data_byte      = out_ff.data_byte;
   assign rsp_store_index    = out_ff.store_index;
   assign rsp_status         = out_ff.status;
   assign rsp_received_total = out_ff.received_total;

   a_held_word_waits: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !consume |=> in_valid_ff && $stable(in_op_ff) && $stable(in_byte_ff))
      else $error("held word lost before processing");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      consume && core_emit |-> out_free)
      else $error("result register overwritten while full");

   a_emit_needs_word: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |=> !out_valid_ff || $past(out_valid_ff))
      else $error("result raised with no word held");

endmodule
